/* rtl/bchd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared codes and constants for the button click / hold detector: gesture
// states, event codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package bchd_pkg;

  // Widths of the fixed fields
  localparam int unsigned STATE_W = 3;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned REG_W   = 2;

  typedef logic [STATE_W-1:0] gesture_t;
  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [REG_W-1:0]   reg_idx_t;

  // Gesture states (per button)
  localparam gesture_t ST_IDLE            = 3'd0;
  localparam gesture_t ST_PRESSED         = 3'd1;
  localparam gesture_t ST_HOLD            = 3'd2;
  localparam gesture_t ST_CLICKED         = 3'd3;
  localparam gesture_t ST_CLICKED_PRESSED = 3'd4;

  // Event codes
  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_SINGLE = 2'd1;
  localparam event_t EV_DOUBLE = 2'd2;
  localparam event_t EV_HOLD   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam reg_idx_t REG_DBL_MASK      = 2'd0;
  localparam reg_idx_t REG_CLICK_TIMEOUT = 2'd1;
  localparam reg_idx_t REG_HOLD_ENTER    = 2'd2;
  localparam reg_idx_t REG_HOLD_REPEAT   = 2'd3;

  // Register reset values
  localparam logic [THR_W-1:0] CLICK_TIMEOUT_RST = 16'd200;
  localparam logic [THR_W-1:0] HOLD_ENTER_RST    = 16'd300;
  localparam logic [THR_W-1:0] HOLD_REPEAT_RST   = 16'd100;

endpackage

/* rtl/button_click_hold_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Per-button click, double-click and hold detection from timestamped samples.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle and its result is loaded into the output
// register in the cycle after; every item gives exactly one result. The rate is
// set by the single registered pass: edge detection, one 32-bit wrapping
// subtract and one compare per button, all buttons in parallel. The input
// stalls only while a finished result is held by out_ready low. Events are
// two bits per button (0 none, 1 single click, 2 double click, 3 hold);
// button i sits in bits 2i+1..2i. Registers at byte addresses 0x0 mask,
// 0x4 click timeout, 0x8 hold enter, 0xC hold repeat, the last three in milliseconds;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module button_click_hold_detector #(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [NUM_BUTTONS-1:0]              in_button_levels,
  input  logic [bchd_pkg::TIME_W-1:0]         in_now_ms,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2*NUM_BUTTONS-1:0]            out_events,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bchd_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [bchd_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [bchd_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  // Configuration registers
  logic [NUM_BUTTONS-1:0]          dbl_mask_r;
  logic [bchd_pkg::THR_W-1:0]      click_timeout_r;
  logic [bchd_pkg::THR_W-1:0]      hold_enter_r;
  logic [bchd_pkg::THR_W-1:0]      hold_repeat_r;

  // Per-button state
  bchd_pkg::gesture_t              state_r   [NUM_BUTTONS];
  bchd_pkg::gesture_t              state_nxt [NUM_BUTTONS];
  logic [bchd_pkg::TIME_W-1:0]     stamp_r   [NUM_BUTTONS];
  logic [bchd_pkg::TIME_W-1:0]     stamp_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]          prev_levels_r;

  // Output register
  logic                            out_valid_r;
  logic [2*NUM_BUTTONS-1:0]        out_events_r;
  logic [2*NUM_BUTTONS-1:0]        events_nxt;

  logic                            in_acc;
  logic                            cfg_wr;
  bchd_pkg::reg_idx_t              cfg_idx;

  // Accept while the output register is empty or being drained
  assign in_ready   = !out_valid_r || out_ready;
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_events = out_events_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[bchd_pkg::ADDR_W-1:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_mask_r      <= '0;
      click_timeout_r <= bchd_pkg::CLICK_TIMEOUT_RST;
      hold_enter_r    <= bchd_pkg::HOLD_ENTER_RST;
      hold_repeat_r   <= bchd_pkg::HOLD_REPEAT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bchd_pkg::REG_DBL_MASK:      dbl_mask_r      <= cfg_pwdata[NUM_BUTTONS-1:0];
        bchd_pkg::REG_CLICK_TIMEOUT: click_timeout_r <= cfg_pwdata[bchd_pkg::THR_W-1:0];
        bchd_pkg::REG_HOLD_ENTER:    hold_enter_r    <= cfg_pwdata[bchd_pkg::THR_W-1:0];
        bchd_pkg::REG_HOLD_REPEAT:   hold_repeat_r   <= cfg_pwdata[bchd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (cfg_idx)
      bchd_pkg::REG_DBL_MASK:
        cfg_prdata = {{(bchd_pkg::DATA_W-NUM_BUTTONS){1'b0}}, dbl_mask_r};
      bchd_pkg::REG_CLICK_TIMEOUT:
        cfg_prdata = {{(bchd_pkg::DATA_W-bchd_pkg::THR_W){1'b0}}, click_timeout_r};
      bchd_pkg::REG_HOLD_ENTER:
        cfg_prdata = {{(bchd_pkg::DATA_W-bchd_pkg::THR_W){1'b0}}, hold_enter_r};
      bchd_pkg::REG_HOLD_REPEAT:
        cfg_prdata = {{(bchd_pkg::DATA_W-bchd_pkg::THR_W){1'b0}}, hold_repeat_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // Run each button's gesture machine on the incoming item
  always_comb begin
    logic                        cur;
    logic                        prev;
    logic                        pressed;
    logic                        released;
    logic                        dbl;
    logic [bchd_pkg::TIME_W-1:0] elapsed;
    logic [bchd_pkg::TIME_W-1:0] click_to;
    logic [bchd_pkg::TIME_W-1:0] hold_in;
    logic [bchd_pkg::TIME_W-1:0] hold_rep;
    bchd_pkg::gesture_t          st;
    bchd_pkg::gesture_t          nx;
    bchd_pkg::event_t            ev;

    click_to   = {{(bchd_pkg::TIME_W-bchd_pkg::THR_W){1'b0}}, click_timeout_r};
    hold_in    = {{(bchd_pkg::TIME_W-bchd_pkg::THR_W){1'b0}}, hold_enter_r};
    hold_rep   = {{(bchd_pkg::TIME_W-bchd_pkg::THR_W){1'b0}}, hold_repeat_r};
    events_nxt = '0;

    for (int b = 0; b < NUM_BUTTONS; b++) begin
      cur      = in_button_levels[b];
      prev     = prev_levels_r[b];
      pressed  = !prev && cur;
      released = prev && !cur;
      dbl      = dbl_mask_r[b];
      elapsed  = in_now_ms - stamp_r[b];
      st       = state_r[b];
      nx       = st;
      ev       = bchd_pkg::EV_NONE;

      case (st)
        bchd_pkg::ST_PRESSED, bchd_pkg::ST_HOLD: begin
          if (released) begin
            if (dbl) begin
              nx = bchd_pkg::ST_CLICKED;
            end else begin
              ev = bchd_pkg::EV_SINGLE;
              nx = bchd_pkg::ST_IDLE;
            end
          end else if (st == bchd_pkg::ST_PRESSED) begin
            if (elapsed > hold_in) begin
              ev = bchd_pkg::EV_HOLD;
              nx = bchd_pkg::ST_HOLD;
            end
          end else if (elapsed > hold_rep) begin
            ev = bchd_pkg::EV_HOLD;
          end
        end
        bchd_pkg::ST_CLICKED: begin
          // timeout wins over a press in the same item
          if (pressed) begin
            nx = bchd_pkg::ST_CLICKED_PRESSED;
          end
          if (elapsed > click_to) begin
            ev = bchd_pkg::EV_SINGLE;
            nx = bchd_pkg::ST_IDLE;
          end
        end
        bchd_pkg::ST_CLICKED_PRESSED: begin
          if (released) begin
            ev = bchd_pkg::EV_DOUBLE;
            nx = bchd_pkg::ST_IDLE;
          end
        end
        default: begin
          // idle, and unused codes act as idle
          nx = pressed ? bchd_pkg::ST_PRESSED : bchd_pkg::ST_IDLE;
        end
      endcase

      state_nxt[b] = nx;
      // restamp on any state change or event
      stamp_nxt[b] = ((nx != st) || (ev != bchd_pkg::EV_NONE)) ? in_now_ms : stamp_r[b];
      events_nxt[2*b +: 2] = ev;
    end
  end

  // Advance button state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        state_r[b] <= bchd_pkg::ST_IDLE;
        stamp_r[b] <= '0;
      end
      prev_levels_r <= '0;
    end else if (in_acc) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        state_r[b] <= state_nxt[b];
        stamp_r[b] <= stamp_nxt[b];
      end
      prev_levels_r <= in_button_levels;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_acc || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_events_r <= events_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item did not produce a result");

  a_event_restamps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (events_nxt[1:0] != bchd_pkg::EV_NONE))
      |=> (stamp_r[0] == $past(in_now_ms)))
    else $error("button 0 event without restamp");

  a_double_from_second_press: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (events_nxt[1:0] == bchd_pkg::EV_DOUBLE))
      |-> (state_r[0] == bchd_pkg::ST_CLICKED_PRESSED))
    else $error("double click reported outside second press");

  a_levels_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (prev_levels_r == $past(in_button_levels)))
    else $error("previous levels not updated on accepted item");

endmodule
